// ===== rtl/core/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared widths, configuration and queue item types for the rotated sprite
// compositor.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int SPRITE_DIM_DEF = 64;
    localparam int FRAME_SIZE_DEF = 4096;

    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 12;
    localparam int ADDR_W     = 12;
    localparam int TEXEL_W    = 4 * BYTE_W;
    localparam int COLOR_W    = 3 * BYTE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int DELTA_W    = 18;
    localparam int PROD_W     = 34;
    localparam int SUM_W      = 36;
    localparam int FRAC_Q     = 18;

    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_A      = 3'd0,
        REG_SIN_A      = 3'd1,
        REG_CENTER_X   = 3'd2,
        REG_CENTER_Y   = 3'd3,
        REG_SPRITE_W   = 3'd4,
        REG_SPRITE_H   = 3'd5,
        REG_ALPHA_MODE = 3'd6,
        REG_ENABLE     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] cos_a;
        logic signed [15:0] sin_a;
        logic signed [16:0] center_x;
        logic signed [16:0] center_y;
        logic [6:0]         sprite_w;
        logic [6:0]         sprite_h;
        logic               alpha_mode;
        logic               enable;
    } t_cfg;

    // queue entry: one classified item
    typedef struct packed {
        logic                       kind;
        logic                       wr_ok;
        logic [ADDR_W-1:0]          texel_addr;
        logic [TEXEL_W-1:0]         texel;
        logic                       draw;
        logic signed [DELTA_W-1:0]  dx;
        logic signed [DELTA_W-1:0]  dy;
        logic [COLOR_W-1:0]         dest;
    } t_item;

endpackage

// ===== rtl/core/rsc_if.sv =====
// ----------------------------------------------------------------------------
// rsc_if
// Channel interfaces: pixel/texel input, result output, register writes.
// ----------------------------------------------------------------------------
interface rsc_pix_if;
    import rsc_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [ADDR_W-1:0]   texel_addr;
    logic [BYTE_W-1:0]   texel_b;
    logic [BYTE_W-1:0]   texel_g;
    logic [BYTE_W-1:0]   texel_r;
    logic [BYTE_W-1:0]   texel_a;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [BYTE_W-1:0]   dest_b;
    logic [BYTE_W-1:0]   dest_g;
    logic [BYTE_W-1:0]   dest_r;

    modport source (
        output valid, kind, texel_addr, texel_b, texel_g, texel_r, texel_a,
               pixel_x, pixel_y, dest_b, dest_g, dest_r,
        input  ready
    );
    modport sink (
        input  valid, kind, texel_addr, texel_b, texel_g, texel_r, texel_a,
               pixel_x, pixel_y, dest_b, dest_g, dest_r,
        output ready
    );
endinterface

interface rsc_res_if;
    import rsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_b;
    logic [BYTE_W-1:0] out_g;
    logic [BYTE_W-1:0] out_r;
    logic              covered;

    modport source (output valid, out_b, out_g, out_r, covered, input ready);
    modport sink (input valid, out_b, out_g, out_r, covered, output ready);
endinterface

interface rsc_cfg_if;
    import rsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rsc_ram.sv =====
// ----------------------------------------------------------------------------
// rsc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/rsc_fifo.sv =====
// ----------------------------------------------------------------------------
// rsc_fifo
// Short show-ahead queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rsc_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  rsc_pkg::t_item         i_item,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output rsc_pkg::t_item         o_item,
    output logic [rsc_pkg::QCW-1:0] o_count
);
    import rsc_pkg::*;

    t_item          r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_count, n_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_count == QCW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign o_count = r_count;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = w_push ? r_wr + 1'b1 : r_wr;
        n_rd    = w_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + QCW'(w_push) - QCW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule

// ===== rtl/core/rsc_front.sv =====
// ----------------------------------------------------------------------------
// rsc_front
// Accepts input items, classifies them and forms the centred offsets.
// ----------------------------------------------------------------------------
module rsc_front #(
    parameter int SPRITE_DIM = rsc_pkg::SPRITE_DIM_DEF,
    parameter int FRAME_SIZE = rsc_pkg::FRAME_SIZE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsc_pkg::t_cfg   i_cfg,
    rsc_pix_if.sink         i_pix,
    output logic            o_push,
    output rsc_pkg::t_item  o_item,
    input  logic            i_full
);
    import rsc_pkg::*;

    localparam int STORE_DEPTH = SPRITE_DIM * SPRITE_DIM;

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  w_accept;

    assign i_pix.ready = !r_valid || !i_full;
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign o_push      = r_valid;
    assign o_item      = r_item;

    always_comb begin
        n_item.kind       = i_pix.kind;
        n_item.texel_addr = i_pix.texel_addr;
        n_item.wr_ok      = (32'(i_pix.texel_addr) < STORE_DEPTH);
        n_item.texel      = {i_pix.texel_a, i_pix.texel_r, i_pix.texel_g, i_pix.texel_b};
        n_item.draw       = i_pix.kind && i_cfg.enable
                            && (32'(i_pix.pixel_x) < FRAME_SIZE)
                            && (32'(i_pix.pixel_y) < FRAME_SIZE)
                            && (i_cfg.sprite_w != '0) && (i_cfg.sprite_h != '0);
        n_item.dx         = $signed({2'b00, i_pix.pixel_x, 4'b0000})
                            - DELTA_W'(i_cfg.center_x);
        n_item.dy         = $signed({2'b00, i_pix.pixel_y, 4'b0000})
                            - DELTA_W'(i_cfg.center_y);
        n_item.dest       = {i_pix.dest_r, i_pix.dest_g, i_pix.dest_b};
        n_valid           = w_accept || (r_valid && i_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end
endmodule

// ===== rtl/core/rsc_back.sv =====
// ----------------------------------------------------------------------------
// rsc_back
// Rotation, bounds check, sprite store access and alpha blend pipeline.
// ----------------------------------------------------------------------------
module rsc_back #(
    parameter int SPRITE_DIM = rsc_pkg::SPRITE_DIM_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsc_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  rsc_pkg::t_item  i_q_item,
    output logic            o_q_pop,
    rsc_res_if.source       o_res
);
    import rsc_pkg::*;

    localparam int STORE_DEPTH = SPRITE_DIM * SPRITE_DIM;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DW = $clog2(SPRITE_DIM + 1);
    localparam int IW = (SPRITE_DIM > 1) ? $clog2(SPRITE_DIM) : 1;
    localparam int RW = IW + DW;

    function automatic logic [BYTE_W-1:0] div255(input logic [16:0] x);
        logic [16:0] t;
        t = x + (x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    logic            w_adv;
    logic [DW-1:0]   w_w, w_h;

    // stage 1: rotation products
    logic                     r_s1_v;
    t_item                    r_s1_item;
    logic signed [PROD_W-1:0] r_s1_pxc, r_s1_pys, r_s1_pxs, r_s1_pyc;
    // stage 2: texel coordinates
    logic                     r_s2_v;
    t_item                    r_s2_item;
    logic                     r_s2_hit;
    logic [IW-1:0]            r_s2_tx, r_s2_ty;
    // stage 3: row offset
    logic                     r_s3_v;
    t_item                    r_s3_item;
    logic                     r_s3_hit;
    logic [IW-1:0]            r_s3_tx;
    logic [RW-1:0]            r_s3_row;
    // stage 4: store read data
    logic                     r_s4_v;
    logic                     r_s4_kind;
    logic                     r_s4_hit;
    logic [COLOR_W-1:0]       r_s4_dest;
    logic [TEXEL_W-1:0]       w_rdata;
    // stage 5: blend products
    logic                     r_s5_v;
    logic                     r_s5_kind;
    logic                     r_s5_hit;
    logic [COLOR_W-1:0]       r_s5_dest;
    logic [COLOR_W-1:0]       r_s5_tex;
    logic [15:0]              r_s5_ps [3];
    logic [15:0]              r_s5_pd [3];
    // output register
    logic                     r_out_v;
    logic [BYTE_W-1:0]        r_out_b, r_out_g, r_out_r;
    logic                     r_out_cov;

    logic signed [SUM_W-1:0]  w_sxq, w_syq, w_half_w, w_half_h;
    logic [DELTA_W-1:0]       w_tx, w_ty;
    logic                     w_hit;
    logic                     w_we;
    logic [AW-1:0]            w_raddr;
    logic [COLOR_W-1:0]       w_blend;
    logic [BYTE_W-1:0]        w_alpha;

    assign w_adv   = !r_out_v || o_res.ready;
    assign o_q_pop = w_adv && i_q_valid;

    assign w_w = (32'(i_cfg.sprite_w) > SPRITE_DIM) ? DW'(SPRITE_DIM) : DW'(i_cfg.sprite_w);
    assign w_h = (32'(i_cfg.sprite_h) > SPRITE_DIM) ? DW'(SPRITE_DIM) : DW'(i_cfg.sprite_h);

    always_comb begin
        w_half_w = SUM_W'($signed({1'b0, w_w, 17'b0}));
        w_half_h = SUM_W'($signed({1'b0, w_h, 17'b0}));
        w_sxq    = SUM_W'(r_s1_pxc) + SUM_W'(r_s1_pys) + w_half_w;
        w_syq    = SUM_W'(r_s1_pyc) - SUM_W'(r_s1_pxs) + w_half_h;
        w_tx     = w_sxq[SUM_W-1:FRAC_Q];
        w_ty     = w_syq[SUM_W-1:FRAC_Q];
        w_hit    = r_s1_item.draw
                   && !w_tx[DELTA_W-1] && (w_tx[DELTA_W-2:0] < (DELTA_W-1)'(w_w))
                   && !w_ty[DELTA_W-1] && (w_ty[DELTA_W-2:0] < (DELTA_W-1)'(w_h));
    end

    assign w_we    = w_adv && r_s3_v && !r_s3_item.kind && r_s3_item.wr_ok;
    assign w_raddr = AW'(r_s3_row + RW'(r_s3_tx));
    assign w_alpha = w_rdata[31:24];

    rsc_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_s3_item.texel_addr)),
        .i_wdata (r_s3_item.texel),
        .i_re    (w_adv),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_blend = {div255(17'(r_s5_ps[2]) + 17'(r_s5_pd[2])),
                   div255(17'(r_s5_ps[1]) + 17'(r_s5_pd[1])),
                   div255(17'(r_s5_ps[0]) + 17'(r_s5_pd[0]))};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v  <= i_q_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_out_v <= r_s5_v && r_s5_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_item <= i_q_item;
            r_s1_pxc  <= i_q_item.dx * i_cfg.cos_a;
            r_s1_pys  <= i_q_item.dy * i_cfg.sin_a;
            r_s1_pxs  <= i_q_item.dx * i_cfg.sin_a;
            r_s1_pyc  <= i_q_item.dy * i_cfg.cos_a;

            r_s2_item <= r_s1_item;
            r_s2_hit  <= w_hit;
            r_s2_tx   <= w_tx[IW-1:0];
            r_s2_ty   <= w_ty[IW-1:0];

            r_s3_item <= r_s2_item;
            r_s3_hit  <= r_s2_hit;
            r_s3_tx   <= r_s2_tx;
            r_s3_row  <= RW'(r_s2_ty) * RW'(w_w);

            r_s4_kind <= r_s3_item.kind;
            r_s4_hit  <= r_s3_hit;
            r_s4_dest <= r_s3_item.dest;

            r_s5_kind <= r_s4_kind;
            r_s5_hit  <= r_s4_hit;
            r_s5_dest <= r_s4_dest;
            r_s5_tex  <= w_rdata[COLOR_W-1:0];
            for (int i = 0; i < 3; i++) begin
                r_s5_ps[i] <= 16'(w_rdata[i*BYTE_W +: BYTE_W]) * 16'(w_alpha);
                r_s5_pd[i] <= 16'(r_s4_dest[i*BYTE_W +: BYTE_W])
                              * 16'(8'd255 - w_alpha);
            end

            r_out_cov <= r_s5_hit;
            if (!r_s5_hit) begin
                {r_out_r, r_out_g, r_out_b} <= r_s5_dest;
            end else if (!i_cfg.alpha_mode) begin
                {r_out_r, r_out_g, r_out_b} <= r_s5_tex;
            end else begin
                {r_out_r, r_out_g, r_out_b} <= w_blend;
            end
        end
    end

    assign o_res.valid   = r_out_v;
    assign o_res.out_b   = r_out_b;
    assign o_res.out_g   = r_out_g;
    assign o_res.out_r   = r_out_r;
    assign o_res.covered = r_out_cov;
endmodule

// ===== rtl/core/rotated_sprite_compositor_core.sv =====
// ----------------------------------------------------------------------------
// rotated_sprite_compositor_core
// Rotated sprite blit with alpha blend over a streamed destination.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix  : input items. kind 0 writes one BGRA texel into the sprite store
//            (no result); kind 1 composites one destination pixel (one result).
//   o_res  : one result per composite item, in input order.
//   i_cfg  : register writes, always ready; write only while the block is idle.
// Path: front register, queue, back-end stages, output register.
// Throughput: one item per cycle while results are taken; loads and
//   composites mix freely; a composite sees every load accepted before it.
// The back end is a single pipeline that advances when the output register
//   is empty or taken; a stalled receiver freezes it, the 4-entry queue and
//   front register fill, then i_pix.ready drops.
// Reset: registers return to their reset values, pipeline and queue empty.
//   The sprite store is not cleared; read only texels already loaded.
// ----------------------------------------------------------------------------
module rotated_sprite_compositor_core #(
    parameter int SPRITE_DIM = rsc_pkg::SPRITE_DIM_DEF,
    parameter int FRAME_SIZE = rsc_pkg::FRAME_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsc_pix_if.sink    i_pix,
    rsc_res_if.source  o_res,
    rsc_cfg_if.sink    i_cfg
);
    import rsc_pkg::*;

    t_cfg           r_cfg;
    logic           w_push;
    t_item          w_front_item;
    logic           w_full;
    logic           w_q_valid;
    t_item          w_q_item;
    logic           w_pop;
    logic [QCW-1:0] w_q_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_a      <= 16'sd16384;
            r_cfg.sin_a      <= '0;
            r_cfg.center_x   <= '0;
            r_cfg.center_y   <= '0;
            r_cfg.sprite_w   <= 7'd64;
            r_cfg.sprite_h   <= 7'd64;
            r_cfg.alpha_mode <= 1'b0;
            r_cfg.enable     <= 1'b1;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_COS_A:      r_cfg.cos_a      <= i_cfg.data[15:0];
                REG_SIN_A:      r_cfg.sin_a      <= i_cfg.data[15:0];
                REG_CENTER_X:   r_cfg.center_x   <= i_cfg.data;
                REG_CENTER_Y:   r_cfg.center_y   <= i_cfg.data;
                REG_SPRITE_W:   r_cfg.sprite_w   <= i_cfg.data[6:0];
                REG_SPRITE_H:   r_cfg.sprite_h   <= i_cfg.data[6:0];
                REG_ALPHA_MODE: r_cfg.alpha_mode <= i_cfg.data[0];
                REG_ENABLE:     r_cfg.enable     <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    rsc_front #(
        .SPRITE_DIM (SPRITE_DIM),
        .FRAME_SIZE (FRAME_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pix   (i_pix),
        .o_push  (w_push),
        .o_item  (w_front_item),
        .i_full  (w_full)
    );

    rsc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .o_count (w_q_count)
    );

    rsc_back #(
        .SPRITE_DIM (SPRITE_DIM)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_pop),
        .o_res     (o_res)
    );

`ifndef SYNTHESIS
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (w_q_count >= $past(w_q_count)))
        else $error("queue drained while output stalled");

    a_backpressure_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (w_q_count == QCW'(Q_DEPTH)))
        else $error("input stalled with room in queue");
`endif
endmodule
